// ----- rtl/bltg_pkg.sv -----
// Shared types and constants for the bilinear tap generator.
`default_nettype none

package bltg_pkg;

  // Fixed-point format of the normalized coordinates.
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int IN_W      = 18;

  // Plane geometry.
  localparam int MAX_DIM   = 4096;
  localparam int SIZE_W    = 13;
  localparam int COORD_W   = $clog2(MAX_DIM);

  // Internal arithmetic widths of the axis mapping.
  localparam int NOFF_W    = IN_W + 1;
  localparam int PROD_W    = NOFF_W + SIZE_W + 1;
  localparam int T_W       = 31;
  localparam int F_W       = T_W - FRAC_BITS - 1;

  // Result widths.
  localparam int IDX_W     = 24;
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int WPROD_W   = 2 * WGT_W;
  localparam int ROW_W     = COORD_W + SIZE_W;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_HEIGHT = 1'b0,
    REG_PLANE_WIDTH  = 1'b1
  } cfg_reg_t;

  // Clamped corner pair and fraction of one axis.
  typedef struct packed {
    logic [COORD_W-1:0]   c0;
    logic [COORD_W-1:0]   c1;
    logic [FRAC_BITS-1:0] frac;
  } axis_tap_t;

endpackage

`default_nettype wire

// ----- rtl/bilinear_tap_generator_unit.sv -----
// Top level of the bilinear tap generator: configuration, pipeline and results.
`default_nettype none

// The block turns one normalized coordinate pair (signed, 16 fractional bits,
// -1..1 spanning the plane) into four clamped flat plane indices and four
// bilinear weights, with 65536 meaning 1.0. It takes one item every clock
// cycle while busy is low; each result appears for a single cycle marked by
// out_valid, after the four register stages (coordinate multiply, floor and
// clamp, row and weight multiplies, index add). busy is high only during
// reset and the cycle after it. The receiver cannot hold results off. A plane
// size of zero acts as one and a size above 4096 acts as 4096; the user must
// write sizes only while no item is in flight, which the block does not
// enforce.
module bilinear_tap_generator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output      logic                                 busy,
  input  wire logic signed [bltg_pkg::IN_W-1:0]     in_norm_x,
  input  wire logic signed [bltg_pkg::IN_W-1:0]     in_norm_y,
  input  wire logic                                 cfg_write_en,
  input  wire logic        [bltg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [bltg_pkg::SIZE_W-1:0]   cfg_data,
  output      logic                                 out_valid,
  output      logic        [bltg_pkg::IDX_W-1:0]    out_index_top_left,
  output      logic        [bltg_pkg::IDX_W-1:0]    out_index_top_right,
  output      logic        [bltg_pkg::IDX_W-1:0]    out_index_bottom_left,
  output      logic        [bltg_pkg::IDX_W-1:0]    out_index_bottom_right,
  output      logic        [bltg_pkg::WGT_W-1:0]    out_weight_top_left,
  output      logic        [bltg_pkg::WGT_W-1:0]    out_weight_top_right,
  output      logic        [bltg_pkg::WGT_W-1:0]    out_weight_bottom_left,
  output      logic        [bltg_pkg::WGT_W-1:0]    out_weight_bottom_right
);
  import bltg_pkg::*;

  localparam int DEPTH = 4;

  logic                busy_r;
  logic                accept;
  logic [DEPTH-1:0]    valid_r;
  logic [SIZE_W-1:0]   plane_height_r;
  logic [SIZE_W-1:0]   plane_width_r;
  logic [SIZE_W-1:0]   eff_size;

  axis_tap_t           tap_x;
  axis_tap_t           tap_y;

  logic [ROW_W-1:0]    row0_full;
  logic [ROW_W-1:0]    row1_full;
  logic [WGT_W-1:0]    ofx;
  logic [WGT_W-1:0]    ofy;
  logic [WGT_W-1:0]    fx;
  logic [WGT_W-1:0]    fy;
  logic [WPROD_W-1:0]  p_tl;
  logic [WPROD_W-1:0]  p_tr;
  logic [WPROD_W-1:0]  p_bl;
  logic [WPROD_W-1:0]  p_br;

  logic [IDX_W-1:0]    row0_r;
  logic [IDX_W-1:0]    row1_r;
  logic [COORD_W-1:0]  x0_r;
  logic [COORD_W-1:0]  x1_r;
  logic [WGT_W-1:0]    w_tl_r;
  logic [WGT_W-1:0]    w_tr_r;
  logic [WGT_W-1:0]    w_bl_r;
  logic [WGT_W-1:0]    w_br_r;

  logic [IDX_W-1:0]    idx_tl_r;
  logic [IDX_W-1:0]    idx_tr_r;
  logic [IDX_W-1:0]    idx_bl_r;
  logic [IDX_W-1:0]    idx_br_r;
  logic [WGT_W-1:0]    wo_tl_r;
  logic [WGT_W-1:0]    wo_tr_r;
  logic [WGT_W-1:0]    wo_bl_r;
  logic [WGT_W-1:0]    wo_br_r;

  // Busy covers reset and the cycle after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Sizes are stored already limited to the supported range.
  always_comb begin
    if (cfg_data == '0) begin
      eff_size = SIZE_W'(1);
    end else if (cfg_data > SIZE_W'(MAX_DIM)) begin
      eff_size = SIZE_W'(MAX_DIM);
    end else begin
      eff_size = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_height_r <= SIZE_W'(64);
      plane_width_r  <= SIZE_W'(64);
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLANE_HEIGHT: plane_height_r <= eff_size;
        REG_PLANE_WIDTH:  plane_width_r  <= eff_size;
        default:          plane_height_r <= plane_height_r;
      endcase
    end
  end

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[DEPTH-2:0], accept};
    end
  end

  // Stages one and two, one mapper per axis.
  bltg_axis_map u_map_x (
    .clk  (clk),
    .norm (in_norm_x),
    .size (plane_width_r),
    .tap  (tap_x)
  );

  bltg_axis_map u_map_y (
    .clk  (clk),
    .norm (in_norm_y),
    .size (plane_height_r),
    .tap  (tap_y)
  );

  // Stage three: row bases and the four truncated weight products.
  always_comb begin
    row0_full = tap_y.c0 * plane_width_r;
    row1_full = tap_y.c1 * plane_width_r;
    fx        = {1'b0, tap_x.frac};
    fy        = {1'b0, tap_y.frac};
    ofx       = WGT_W'(ONE) - fx;
    ofy       = WGT_W'(ONE) - fy;
    p_tl      = ofx * ofy;
    p_tr      = fx * ofy;
    p_bl      = ofx * fy;
    p_br      = fx * fy;
  end

  always_ff @(posedge clk) begin
    row0_r <= row0_full[IDX_W-1:0];
    row1_r <= row1_full[IDX_W-1:0];
    x0_r   <= tap_x.c0;
    x1_r   <= tap_x.c1;
    w_tl_r <= p_tl[FRAC_BITS+WGT_W-1:FRAC_BITS];
    w_tr_r <= p_tr[FRAC_BITS+WGT_W-1:FRAC_BITS];
    w_bl_r <= p_bl[FRAC_BITS+WGT_W-1:FRAC_BITS];
    w_br_r <= p_br[FRAC_BITS+WGT_W-1:FRAC_BITS];
  end

  // Stage four: flat indices and the output register.
  always_ff @(posedge clk) begin
    idx_tl_r <= row0_r + IDX_W'(x0_r);
    idx_tr_r <= row0_r + IDX_W'(x1_r);
    idx_bl_r <= row1_r + IDX_W'(x0_r);
    idx_br_r <= row1_r + IDX_W'(x1_r);
    wo_tl_r  <= w_tl_r;
    wo_tr_r  <= w_tr_r;
    wo_bl_r  <= w_bl_r;
    wo_br_r  <= w_br_r;
  end

  assign out_valid               = valid_r[DEPTH-1];
  assign out_index_top_left      = idx_tl_r;
  assign out_index_top_right     = idx_tr_r;
  assign out_index_bottom_left   = idx_bl_r;
  assign out_index_bottom_right  = idx_br_r;
  assign out_weight_top_left     = wo_tl_r;
  assign out_weight_top_right    = wo_tr_r;
  assign out_weight_bottom_left  = wo_bl_r;
  assign out_weight_bottom_right = wo_br_r;

endmodule

`default_nettype wire

// ----- rtl/bltg_axis_map.sv -----
// Two-stage mapping of one normalized coordinate to clamped corners and fraction.
`default_nettype none

module bltg_axis_map (
  input  wire logic                                clk,
  input  wire logic signed [bltg_pkg::IN_W-1:0]    norm,
  input  wire logic        [bltg_pkg::SIZE_W-1:0]  size,
  output      bltg_pkg::axis_tap_t                 tap
);
  import bltg_pkg::*;

  logic signed [NOFF_W-1:0]  n_off;
  logic signed [SIZE_W:0]    size_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  t_full;
  logic        [T_W-1:0]     t_r;
  logic        [T_W-1:0]     t_nxt;

  logic signed [F_W-1:0]     f;
  logic signed [F_W:0]       fp1;
  logic        [COORD_W-1:0] hi;
  logic signed [F_W-1:0]     hi_s;
  logic signed [F_W:0]       hi_s1;
  axis_tap_t                 tap_r;
  axis_tap_t                 tap_nxt;

  // Stage one: pixel coordinate with one extra fractional bit, (n+1)*size-1.
  always_comb begin
    n_off  = {norm[IN_W-1], norm} + NOFF_W'(ONE);
    size_s = $signed({1'b0, size});
    prod   = n_off * size_s;
    t_full = prod - PROD_W'(ONE);
    t_nxt  = t_full[T_W-1:0];
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  // Stage two: floor, fraction and border clamp of both corners.
  always_comb begin
    f     = t_r[T_W-1:FRAC_BITS+1];
    fp1   = {f[F_W-1], f} + (F_W+1)'(1);
    hi    = COORD_W'(size - SIZE_W'(1));
    hi_s  = $signed({{(F_W-COORD_W){1'b0}}, hi});
    hi_s1 = $signed({{(F_W+1-COORD_W){1'b0}}, hi});

    if (f[F_W-1]) begin
      tap_nxt.c0 = '0;
    end else if (f > hi_s) begin
      tap_nxt.c0 = hi;
    end else begin
      tap_nxt.c0 = f[COORD_W-1:0];
    end

    if (fp1[F_W]) begin
      tap_nxt.c1 = '0;
    end else if (fp1 > hi_s1) begin
      tap_nxt.c1 = hi;
    end else begin
      tap_nxt.c1 = fp1[COORD_W-1:0];
    end

    tap_nxt.frac = t_r[FRAC_BITS:1];
  end

  always_ff @(posedge clk) begin
    tap_r <= tap_nxt;
  end

  assign tap = tap_r;

endmodule

`default_nettype wire

// ----- rtl/bltg_checker.sv -----
// Port-level checks of the bilinear tap generator and their bind.
`default_nettype none

module bltg_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [bltg_pkg::IDX_W-1:0]    out_index_top_left,
  input wire logic [bltg_pkg::IDX_W-1:0]    out_index_top_right,
  input wire logic [bltg_pkg::IDX_W-1:0]    out_index_bottom_left,
  input wire logic [bltg_pkg::IDX_W-1:0]    out_index_bottom_right,
  input wire logic [bltg_pkg::WGT_W-1:0]    out_weight_top_left,
  input wire logic [bltg_pkg::WGT_W-1:0]    out_weight_top_right,
  input wire logic [bltg_pkg::WGT_W-1:0]    out_weight_bottom_left,
  input wire logic [bltg_pkg::WGT_W-1:0]    out_weight_bottom_right
);
  import bltg_pkg::*;

  logic             acc;
  logic [WGT_W+1:0] wsum;

  assign acc  = start && !busy;
  assign wsum = {2'b00, out_weight_top_left} + {2'b00, out_weight_top_right}
              + {2'b00, out_weight_bottom_left} + {2'b00, out_weight_bottom_right};

  // Every result comes from a matching accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 4))
    else $error("result without a matching item");

  // An item taken with no reset since then yields its result.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(acc, 4) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
     && $past(rst_n, 4)) |-> out_valid)
    else $error("accepted item produced no result");

  // Truncated weights add up to one, less at most three units.
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (wsum <= (WGT_W+2)'(ONE) && wsum >= (WGT_W+2)'(ONE - 3)))
    else $error("weights do not sum to one");

  // The far corners never lie before the near corners.
  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_index_top_left <= out_index_top_right
                   && out_index_top_left <= out_index_bottom_left
                   && out_index_bottom_left <= out_index_bottom_right))
    else $error("corner indices out of order");

  // Busy drops once reset has been released for a cycle.
  a_busy_release: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy held after reset");

endmodule

bind bilinear_tap_generator_unit bltg_checker u_bltg_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .start                   (start),
  .busy                    (busy),
  .out_valid               (out_valid),
  .out_index_top_left      (out_index_top_left),
  .out_index_top_right     (out_index_top_right),
  .out_index_bottom_left   (out_index_bottom_left),
  .out_index_bottom_right  (out_index_bottom_right),
  .out_weight_top_left     (out_weight_top_left),
  .out_weight_top_right    (out_weight_top_right),
  .out_weight_bottom_left  (out_weight_bottom_left),
  .out_weight_bottom_right (out_weight_bottom_right)
);

`default_nettype wire
